@@ design/mtf_pkg.sv @@
// shared types and constants for the mersenne trial factor test block
`default_nettype none
package mtf_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_SKIP       = 3'd0,
      ST_NOT_FACTOR = 3'd1,
      ST_FACTOR     = 3'd2,
      ST_OVER_LIMIT = 3'd3,
      ST_TOO_WIDE   = 3'd4
   } status_type;

   localparam int unsigned ORDER_W = 32;
   localparam int unsigned K_W     = 62;
   localparam int unsigned Q_W     = 64;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture k and order
      logic mul_lo;    // low half of k times 2*order
      logic mul_hi;    // high half of k times 2*order, added to the low half
      logic form_q;    // form q and the width check from the product
      logic mm_start;  // start a modular multiply (res*base or base*base)
      logic mm_sel_sq; // operands of the multiply being started, 1: base*base, 0: res*base
      logic mm_step;   // one double-and-add step
      logic mm_done;   // write multiply result back
      logic wb_sq;     // write-back target, 1: base, 0: res
      logic exp_shift; // shift exponent right
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic too_wide;
      logic skip;
      logic exp_zero;
      logic exp_bit;
      logic mm_last;
      logic is_one;
   } stat_type;

endpackage
`default_nettype wire

@@ design/mersenne_trial_factor_test.sv @@
// top level of the mersenne trial factor test block
// One request at a time: after acceptance the candidate q = 2*k*order+1 is formed from
// two 31x33 partial products, then q and the width check, and a check state decides
// skip, too wide or test. Each exponent bit then costs a selection state plus one
// modular multiply (64 double-and-add steps and a write-back) when clear,
// two multiplies when set. Skipped or too-wide candidates respond straight after the
// check. The next request is taken after the response leaves. The user must write the
// order register through the csr port only while no request is in flight; the block
// itself does not enforce this.
`default_nettype none
module mersenne_trial_factor_test #(
   parameter int unsigned HIT_CAPACITY = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [61:0] req_k_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_candidate,
   output logic [63:0]      rsp_tested_count,
   output logic [12:0]      rsp_found_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   mtf_pkg::cmd_type  cmd;
   mtf_pkg::stat_type stat;
   logic [31:0] order_ff;

   // order register
   always_ff @(posedge clock) begin
      if (reset) order_ff <= 32'd3;
      else if (csr_valid) order_ff <= csr_data;
   end
   assign csr_ready = 1'b1;

   mtf_control #(.HIT_CAPACITY(HIT_CAPACITY)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd, .rsp_status, .rsp_tested_count, .rsp_found_count
   );

   mtf_datapath u_dp (
      .clock, .cmd, .k_value(req_k_value), .order(order_ff), .stat,
      .candidate(rsp_candidate)
   );

endmodule
`default_nettype wire

@@ design/mtf_datapath.sv @@
// datapath: candidate forming, modular multiply unit and exponent register
`default_nettype none
module mtf_datapath (
   input  wire logic                     clock,
   input  wire mtf_pkg::cmd_type         cmd,
   input  wire logic [61:0]              k_value,
   input  wire logic [31:0]              order,
   output mtf_pkg::stat_type             stat,
   output logic [63:0]                   candidate
);

   logic [61:0] k_ff, k_in;
   logic [32:0] twice_ff, twice_in;
   logic [95:0] prod_ff, prod_in;
   logic [63:0] q_ff, q_in;
   logic        wide_ff, wide_in;
   logic [31:0] exp_ff, exp_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] b_ff, b_in;
   logic [5:0]  bit_ff, bit_in;

   logic [95:0] qfull;
   logic [63:0] a1, a2;
   logic [64:0] s1, s2;
   logic [30:0] k_part;
   logic [63:0] pp;

   // full product k * 2*order, built from two 31x33 partial products
   assign qfull = prod_ff;

   // one partial product per cycle, low half of k first
   assign k_part = cmd.mul_hi ? k_ff[61:31] : k_ff[30:0];
   assign pp     = {33'd0, k_part} * {31'd0, twice_ff};

   // add_mod helpers: acc+acc then optional +x, both modulo q
   always_comb begin
      s1 = {1'b0, acc_ff} + {1'b0, acc_ff};
      a1 = (s1 >= {1'b0, q_ff}) ? 64'(s1 - {1'b0, q_ff}) : s1[63:0];
      s2 = {1'b0, a1} + {1'b0, x_ff};
      a2 = (s2 >= {1'b0, q_ff}) ? 64'(s2 - {1'b0, q_ff}) : s2[63:0];
      if (!b_ff[63]) a2 = a1;
   end

   always_comb begin
      k_in = k_ff; twice_in = twice_ff; prod_in = prod_ff; q_in = q_ff;
      wide_in = wide_ff; exp_in = exp_ff; res_in = res_ff; base_in = base_ff;
      acc_in = acc_ff; x_in = x_ff; b_in = b_ff; bit_in = bit_ff;
      // capture operands
      if (cmd.load) begin
         k_in     = k_value;
         twice_in = {order, 1'b0};
         exp_in   = order;
      end
      // product k * 2*order, low partial product first, then the high one added
      if (cmd.mul_lo) prod_in = {32'd0, pp};
      if (cmd.mul_hi) prod_in = prod_ff + {1'b0, pp, 31'd0};
      // candidate and width check
      if (cmd.form_q) begin
         wide_in = (qfull[95:64] != 32'd0) || (qfull[63:0] == 64'hFFFF_FFFF_FFFF_FFFF);
         q_in    = qfull[63:0] + 64'd1;
         // q==1 gives 1 mod 1 == 0, 2 mod 1 == 0
         res_in  = (qfull[63:0] == 64'd0) ? 64'd0 : 64'd1;
         base_in = (qfull[63:0] == 64'd0) ? 64'd0 : 64'd2;
      end
      // modular multiply sequencing (operands already reduced below q)
      if (cmd.mm_start) begin
         acc_in = 64'd0;
         x_in   = base_ff;
         b_in   = cmd.mm_sel_sq ? base_ff : res_ff;
         bit_in = 6'd0;
      end
      if (cmd.mm_step) begin
         acc_in = a2;
         b_in   = {b_ff[62:0], 1'b0};
         bit_in = 6'(bit_ff + 6'd1);
      end
      if (cmd.mm_done) begin
         if (cmd.wb_sq) base_in = acc_ff;
         else           res_in  = acc_ff;
      end
      if (cmd.exp_shift) exp_in = {1'b0, exp_ff[31:1]};
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; twice_ff <= twice_in; prod_ff <= prod_in; q_ff <= q_in;
      wide_ff <= wide_in; exp_ff <= exp_in; res_ff <= res_in; base_ff <= base_in;
      acc_ff <= acc_in; x_ff <= x_in; b_ff <= b_in; bit_ff <= bit_in;
   end

   assign stat.too_wide = wide_ff;
   assign stat.skip     = !(q_ff[2:0] inside {3'd1, 3'd7});
   assign stat.exp_zero = (exp_ff == 32'd0);
   assign stat.exp_bit  = exp_ff[0];
   assign stat.mm_last  = (bit_ff == 6'd63);
   assign stat.is_one   = (res_ff == 64'd1);
   assign candidate     = wide_ff ? 64'd0 : q_ff;

endmodule
`default_nettype wire

@@ design/mtf_control.sv @@
// controller: sequences candidate forming and square-and-multiply, keeps counters
`default_nettype none
module mtf_control #(
   parameter int unsigned HIT_CAPACITY = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire mtf_pkg::stat_type stat,
   output mtf_pkg::cmd_type       cmd,
   output logic [2:0]             rsp_status,
   output logic [63:0]            rsp_tested_count,
   output logic [12:0]            rsp_found_count
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_MUL   = 9'b0_0000_0010,
      S_FORM  = 9'b0_0000_0100,
      S_CHECK = 9'b0_0000_1000,
      S_NEXT  = 9'b0_0001_0000,
      S_MM    = 9'b0_0010_0000,
      S_MMWB  = 9'b0_0100_0000,
      S_OUT   = 9'b0_1000_0000,
      S_MULH  = 9'b1_0000_0000
   } state_type;

   localparam int unsigned CNT_W = $clog2(HIT_CAPACITY + 1);

   state_type   state_ff, state_in;
   logic        sq_ff, sq_in;
   logic [63:0] tested_ff, tested_in;
   logic [CNT_W-1:0] found_ff, found_in;
   logic [2:0]  status_ff, status_in;

   always_comb begin
      state_in = state_ff; sq_in = sq_ff; tested_in = tested_ff;
      found_in = found_ff; status_in = status_ff;
      cmd = '0;
      cmd.mm_sel_sq = sq_ff;
      cmd.wb_sq = sq_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MULH;
         end
         S_MULH: begin
            cmd.mul_hi = 1'b1;
            state_in = S_FORM;
         end
         S_FORM: begin
            cmd.form_q = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.too_wide) begin
               status_in = mtf_pkg::ST_TOO_WIDE;
               state_in = S_OUT;
            end else if (stat.skip) begin
               status_in = mtf_pkg::ST_SKIP;
               state_in = S_OUT;
            end else begin
               if (tested_ff != 64'hFFFF_FFFF_FFFF_FFFF) tested_in = tested_ff + 64'd1;
               state_in = S_NEXT;
            end
         end
         // pick next multiply of the exponent loop, or decide the result once the exponent is zero
         S_NEXT: begin
            if (stat.exp_zero) begin
               if (!stat.is_one) status_in = mtf_pkg::ST_NOT_FACTOR;
               else if (found_ff < CNT_W'(HIT_CAPACITY)) begin
                  found_in  = found_ff + CNT_W'(1);
                  status_in = mtf_pkg::ST_FACTOR;
               end else status_in = mtf_pkg::ST_OVER_LIMIT;
               state_in = S_OUT;
            end else begin
               sq_in = !stat.exp_bit;
               cmd.mm_start = 1'b1;
               cmd.mm_sel_sq = !stat.exp_bit;
               state_in = S_MM;
            end
         end
         S_MM: begin
            cmd.mm_step = 1'b1;
            if (stat.mm_last) state_in = S_MMWB;
         end
         // write back the finished multiply; after res*base the square follows
         S_MMWB: begin
            cmd.mm_done = 1'b1;
            if (sq_ff) begin
               cmd.exp_shift = 1'b1;
               state_in = S_NEXT;
            end else begin
               sq_in = 1'b1;
               cmd.mm_start = 1'b1;
               cmd.mm_sel_sq = 1'b1;
               state_in = S_MM;
            end
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tested_ff <= 64'd0;
         found_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         tested_ff <= tested_in;
         found_ff  <= found_in;
      end
      sq_ff     <= sq_in;
      status_ff <= status_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_status       = status_ff;
   assign rsp_tested_count = tested_ff;
   assign rsp_found_count  = 13'(found_ff);

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the mersenne trial factor test block
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // hit capacity of the default configuration
   localparam int unsigned HIT_CAP = 4096;
   localparam logic [61:0] K_ALL = {62{1'b1}};

   typedef struct {
      mtf_pkg::status_type status;
      logic [63:0] candidate;
      logic [63:0] tested;
      logic [12:0] found;
   } trial_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [61:0] req_k_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_candidate;
   logic [63:0] rsp_tested_count;
   logic [12:0] rsp_found_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // shadow of the block state
   logic [31:0] order_shadow;
   logic [63:0] tested_tally;
   logic [12:0] found_tally;

   logic [61:0]      k_pending[$];
   trial_result_type trials_due[$];
   int unsigned   errors = 0;
   int unsigned   send_gap = 0;
   int unsigned   stall_gap = 0;
   bit            calm = 1'b0;

   mersenne_trial_factor_test #(.HIT_CAPACITY(HIT_CAP)) DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // 2^e mod m with exact products
   function automatic logic [63:0] pow2_residue(input logic [31:0] e, input logic [63:0] m);
      logic [127:0] r;
      logic [127:0] b;
      logic [127:0] mw;
      mw = {64'd0, m};
      r = 128'd1 % mw;
      b = 128'd2 % mw;
      for (int i = 0; i < 32; i++) begin
         if (e[i]) r = (r * b) % mw;
         b = (b * b) % mw;
      end
      return r[63:0];
   endfunction

   // predicted result of one trial, updating the shadow counters
   function automatic trial_result_type predict_trial(input logic [61:0] k);
      trial_result_type t;
      logic [63:0] twice;
      logic [63:0] q;
      twice = {31'd0, order_shadow, 1'b0};
      if (twice != 0 && {2'b00, k} > (64'hFFFF_FFFF_FFFF_FFFE / twice)) begin
         t.status = mtf_pkg::ST_TOO_WIDE;
         q = '0;
      end else begin
         q = {2'b00, k} * twice + 64'd1;
         if (!(q[2:0] inside {3'd1, 3'd7})) begin
            t.status = mtf_pkg::ST_SKIP;
         end else begin
            if (tested_tally != '1) tested_tally++;
            if (pow2_residue(order_shadow, q) == 64'd1) begin
               if (found_tally < HIT_CAP) begin
                  found_tally++;
                  t.status = mtf_pkg::ST_FACTOR;
               end else begin
                  t.status = mtf_pkg::ST_OVER_LIMIT;
               end
            end else begin
               t.status = mtf_pkg::ST_NOT_FACTOR;
            end
         end
      end
      t.candidate = q;
      t.tested = tested_tally;
      t.found = found_tally;
      return t;
   endfunction

   // driver: presents pending requests, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) trials_due.push_back(predict_trial(req_k_value));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (k_pending.size() > 0) begin
               req_k_value <= k_pending.pop_front();
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results and stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (trials_due.size() == 0) begin
               $display("%0t: unexpected result status %0d candidate %0h", $time,
                        rsp_status, rsp_candidate);
               errors++;
            end else begin
               trial_result_type t;
               t = trials_due.pop_front();
               if (rsp_status !== t.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, t.status, rsp_status);
                  errors++;
               end
               if (rsp_candidate !== t.candidate) begin
                  $display("%0t: candidate expected %0h actual %0h", $time, t.candidate,
                           rsp_candidate);
                  errors++;
               end
               if (rsp_tested_count !== t.tested) begin
                  $display("%0t: tested_count expected %0d actual %0d", $time, t.tested,
                           rsp_tested_count);
                  errors++;
               end
               if (rsp_found_count !== t.found) begin
                  $display("%0t: found_count expected %0d actual %0d", $time, t.found,
                           rsp_found_count);
                  errors++;
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // wait until no request is queued, presented or outstanding, then align to a rising edge
   task automatic drain_requests();
      do @(negedge clock);
      while (k_pending.size() > 0 || req_valid || trials_due.size() > 0);
      @(posedge clock);
   endtask

   // write the order register while idle
   task automatic write_order(input logic [31:0] v);
      drain_requests();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      order_shadow = v;
   endtask

   // boundary of the too-wide check for the current order, clipped to the k range
   function automatic logic [61:0] width_edge();
      logic [63:0] lim;
      if (order_shadow == 0) return K_ALL;
      lim = 64'hFFFF_FFFF_FFFF_FFFE / {31'd0, order_shadow, 1'b0};
      return (lim >= {2'b00, K_ALL}) ? K_ALL : lim[61:0];
   endfunction

   function automatic logic [61:0] random_k();
      logic [61:0] e;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      e = width_edge();
      if (pick < 4) return 62'($urandom_range(0, 40));
      if (pick < 7) return 62'({$urandom, $urandom});
      if (pick < 9) return (e == K_ALL) ? e : e + 62'($urandom_range(0, 1));
      return 62'({$urandom_range(0, 1023), 20'd0}) ^
             62'({$urandom, $urandom} >> $urandom_range(0, 61));
   endfunction

   initial begin
      logic [31:0] small_orders[6];
      int unsigned n;
      small_orders = '{32'd3, 32'd11, 32'd23, 32'd29, 32'd5, 32'd37};
      order_shadow = 32'd3;
      tested_tally = '0;
      found_tally = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default order: factor, skips, a plain test, extremes of k and the width edge
      k_pending = '{62'd1, 62'd0, 62'd2, 62'd3, 62'd4, K_ALL, width_edge(),
                    width_edge() + 62'd1};
      // order zero: every candidate is one
      write_order(32'd0);
      k_pending = '{62'd0, 62'd5, K_ALL};
      // orders one, two and even
      write_order(32'd1);
      k_pending = '{62'd0, 62'd1, 62'd6};
      write_order(32'd2);
      k_pending = '{62'd1, 62'd2};
      write_order(32'd4);
      k_pending = '{62'd1, 62'd2, 62'd3};
      // largest order: a long test, the candidate one, the width edge and too wide
      write_order(32'hFFFF_FFFF);
      k_pending = '{62'd1, 62'd0, width_edge(), width_edge() + 62'd1};
      // order with two small factors
      write_order(32'd11);
      k_pending = '{62'd1, 62'd4};

      // random part over several small orders, the last phase without idling
      for (int p = 0; p < 9; p++) begin
         if (p == 8) calm = 1'b1;
         if (p == 4) write_order($urandom_range(3, 255) | 32'd1);
         else write_order(small_orders[$urandom_range(0, 5)]);
         n = (p == 8) ? 56 : 62;
         for (int i = 0; i < n; i++) k_pending.push_back(random_k());
      end
      // one more long test at a random large order
      write_order($urandom | 32'h8000_0001);
      k_pending.push_back(62'd1);
      k_pending.push_back(62'({$urandom, $urandom}));
      drain_requests();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
